>>> design/vdd_pkg.sv
// Shared types and constants for the vertex deduplication table.
// No dependencies; imported by every module of the block.
package vdd_pkg;

  // One table entry: six 64-bit words of vertex attributes.
  localparam int WORDS_PER_ENTRY = 6;
  localparam int WORD_W          = 64;
  localparam int ENTRY_W         = WORDS_PER_ENTRY * WORD_W;
  localparam int INDEX_W         = 10;

  typedef logic [ENTRY_W-1:0] vdd_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } vdd_state_t;

  // Control from the sequencer to the entry memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } vdd_mem_req_t;

endpackage

>>> design/vdd_entry_mem.sv
// Entry memory of the deduplication table: one full vertex per row.
// Depends on vdd_pkg; one address shared by the write and a read with registered data.
module vdd_entry_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                 clk,
  input  vdd_pkg::vdd_mem_req_t req,
  input  logic [AW-1:0]        addr,
  input  vdd_pkg::vdd_entry_t  wr_data,
  output vdd_pkg::vdd_entry_t  rd_data
);
  import vdd_pkg::*;

  vdd_entry_t mem [DEPTH];
  vdd_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/vdd_search_ctrl.sv
// Search sequencer: walks the table one entry per cycle through a shared
// 384-bit comparator, then reports a hit, appends or flags full. Depends on vdd_pkg.
module vdd_search_ctrl #(
  parameter int TABLE_DEPTH = 1024,
  parameter int AW          = 10,
  parameter int CW          = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_som,
  input  vdd_pkg::vdd_entry_t         in_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vdd_pkg::INDEX_W-1:0] out_index,
  output logic                        out_is_new,
  output logic                        out_full,
  output vdd_pkg::vdd_mem_req_t       mem_req,
  output logic [AW-1:0]               mem_addr,
  output vdd_pkg::vdd_entry_t         mem_wdata,
  input  vdd_pkg::vdd_entry_t         mem_rdata
);
  import vdd_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  vdd_state_t           state_r, state_nxt;
  vdd_entry_t           key_r, key_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [INDEX_W-1:0]   res_idx_r, res_idx_nxt;
  logic                 res_new_r, res_new_nxt;
  logic                 res_full_r, res_full_nxt;
  logic                 hit;
  logic                 scan_end;

  // Shared comparator: the row read last cycle against the held vertex.
  assign hit      = rd_vld_r && (mem_rdata == key_r);
  assign scan_end = hit || (ptr_r == count_r);
  assign mem_wdata = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid)  state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end)  state_nxt = ST_DONE;
      ST_DONE: if (out_ready) state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    key_nxt      = key_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    cmp_idx_nxt  = cmp_idx_r;
    rd_vld_nxt   = 1'b0;
    res_idx_nxt  = res_idx_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    mem_req      = '0;
    mem_addr     = ptr_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt = in_key;
          ptr_nxt = '0;
          if (in_som) begin
            count_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_idx_nxt  = INDEX_W'(cmp_idx_r);
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
        end else if (ptr_r != count_r) begin
          mem_req.rd_en = 1'b1;
          rd_vld_nxt    = 1'b1;
          cmp_idx_nxt   = ptr_r[AW-1:0];
          ptr_nxt       = ptr_r + 1'b1;
        end else if (count_r == DEPTH_C) begin
          res_idx_nxt  = '0;
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b1;
        end else begin
          mem_req.wr_en = 1'b1;
          mem_addr      = count_r[AW-1:0];
          res_idx_nxt   = INDEX_W'(count_r);
          res_new_nxt   = 1'b1;
          res_full_nxt  = 1'b0;
          count_nxt     = count_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_index  = res_idx_r;
  assign out_is_new = res_new_r;
  assign out_full   = res_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("unique count exceeds table depth");

  a_som_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_som) |=> (count_r == '0))
    else $error("start of mesh did not empty the table");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (ptr_r <= count_r))
    else $error("search pointer ran past the filled entries");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (count_r < DEPTH_C) && !mem_req.rd_en)
    else $error("append into a full table or with a read");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_full))
    else $error("result both appended and full");

endmodule

>>> design/vertex_dedup_index_table.sv
// Top level of the vertex deduplication table.
// Depends on vdd_pkg, vdd_entry_mem and vdd_search_ctrl.
// A request that misses compares every filled entry before its result shows;
// a hit at entry k ends the scan once row k has compared. One request is in
// flight at a time; the next can be taken in the cycle after the result is
// taken. The scan reads one memory row per cycle through a single read port
// and one shared 384-bit comparator.
// Reset (rst_n low, synchronous) empties the table; memory rows need none.
module vertex_dedup_index_table #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_start_of_mesh,
  input  logic [31:0]                 in_pos_x,
  input  logic [31:0]                 in_pos_y,
  input  logic [31:0]                 in_pos_z,
  input  logic [31:0]                 in_norm_x,
  input  logic [31:0]                 in_norm_y,
  input  logic [31:0]                 in_norm_z,
  input  logic [63:0]                 in_tex_uv,
  input  logic [31:0]                 in_col_r,
  input  logic [31:0]                 in_col_g,
  input  logic [31:0]                 in_col_b,
  input  logic [31:0]                 in_col_a,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vdd_pkg::INDEX_W-1:0] out_vertex_index,
  output logic                        out_is_new,
  output logic                        out_table_full
);
  import vdd_pkg::*;

  // Address width covers the rows; count width also holds the depth itself.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  vdd_entry_t   key;
  vdd_entry_t   mem_wdata;
  vdd_entry_t   mem_rdata;
  vdd_mem_req_t mem_req;
  logic [AW-1:0] mem_addr;

  // Pack the request into one row; word order matches a stored entry,
  // so a bitwise compare of the whole row is an exact attribute match.
  assign key = {in_pos_x, in_pos_y,
                in_pos_z, in_norm_x,
                in_norm_y, in_norm_z,
                in_tex_uv,
                in_col_r, in_col_g,
                in_col_b, in_col_a};

  vdd_search_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_som     (in_start_of_mesh),
    .in_key     (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_index  (out_vertex_index),
    .out_is_new (out_is_new),
    .out_full   (out_table_full),
    .mem_req    (mem_req),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  // Rows are written only when appended and read only below the count,
  // so an unwritten row is never compared.
  vdd_entry_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .addr    (mem_addr),
    .wr_data (mem_wdata),
    .rd_data (mem_rdata)
  );

endmodule
